// ----- rtl/lfc_pkg.sv -----
// Shared constants for the link failover controller: register map and field widths.
package lfc_pkg;

	// Width of the millisecond time and of every timeout register
	localparam int unsigned TimeW = 32;
	// Width of the APB data and address buses
	localparam int unsigned ApbDataW = 32;
	localparam int unsigned ApbAddrW = 4;
	// Width of the reported state code
	localparam int unsigned StateW = 3;

	// Register indexes (byte address is four times the index)
	typedef enum logic [1:0] {
		REG_WIRED_PRESENT  = 2'd0,
		REG_WIRED_TMO      = 2'd1,
		REG_WIRELESS_TMO   = 2'd2,
		REG_CLOUD_TMO      = 2'd3
	} reg_idx_t;

	// Reset values of the timeout registers
	localparam logic [TimeW-1:0] WiredTmoRst    = 32'd30000;
	localparam logic [TimeW-1:0] WirelessTmoRst = 32'd30000;
	localparam logic [TimeW-1:0] CloudTmoRst    = 32'd60000;

	// Command strobes given with one result
	typedef struct packed {
		logic wired_connect;
		logic wired_disconnect;
		logic wireless_connect;
		logic wireless_disconnect;
		logic cloud_connect;
		logic cloud_disconnect;
	} strobe_t;

endpackage

// ----- rtl/link_failover_controller_top.sv -----
// Link failover controller: poll register, state machine with wait timer, result register.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------------------
//  poll in  | in_valid/in_ready  | now_ms, cloud_up, wired_ready, wireless_ready,
//           |                    | wireless_credentials
//  result   | out_valid/out_ready| link_state, online, wired_connect, wired_disconnect,
//           |                    | wireless_connect, wireless_disconnect, cloud_connect,
//           |                    | cloud_disconnect
//  config   | APB psel/penable   | paddr, pwdata, prdata (registers at 0x0, 0x4, 0x8, 0xC)
//
// A poll is registered in the poll register on acceptance, its result in the result register
// once that is free or emptying; one poll accepted per cycle when the result side keeps up.
// The state update and the single subtract-and-compare of the wait timer are combinational.
// Reset clears the state to wired start and loads the register reset values.
// When the result register is held by out_ready low, the poll register fills and then
// in_ready drops; nothing is lost.
module link_failover_controller_top
	import lfc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// APB configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ApbAddrW-1:0] paddr,
	input  logic [ApbDataW-1:0] pwdata,
	output logic [ApbDataW-1:0] prdata,
	output logic                pready,
	// poll channel
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [TimeW-1:0]    now_ms,
	input  logic                cloud_up,
	input  logic                wired_ready,
	input  logic                wireless_ready,
	input  logic                wireless_credentials,
	// result channel
	output logic                out_valid,
	input  logic                out_ready,
	output logic [StateW-1:0]   link_state,
	output logic                online,
	output logic                wired_connect,
	output logic                wired_disconnect,
	output logic                wireless_connect,
	output logic                wireless_disconnect,
	output logic                cloud_connect,
	output logic                cloud_disconnect
);

	typedef enum logic [StateW-1:0] {
		ST_WIRED_START  = 3'd0,
		ST_WIRED_WAIT   = 3'd1,
		ST_WIRED_CLOUD  = 3'd2,
		ST_WIRED_ONLINE = 3'd3,
		ST_WL_START     = 3'd4,
		ST_WL_WAIT      = 3'd5,
		ST_WL_CLOUD     = 3'd6,
		ST_WL_ONLINE    = 3'd7
	} state_t;

	// configuration registers
	logic             wired_present_q;
	logic [TimeW-1:0] wired_tmo_q;
	logic [TimeW-1:0] wireless_tmo_q;
	logic [TimeW-1:0] cloud_tmo_q;

	// poll register
	logic             valid_s1;
	logic [TimeW-1:0] now_s1;
	logic             cloud_s1;
	logic             wired_rdy_s1;
	logic             wl_rdy_s1;
	logic             creds_s1;

	// controller state and wait timer
	state_t           state_q;
	logic [TimeW-1:0] wait_start_q;
	logic [TimeW-1:0] wait_len_q;

	// result register
	logic             valid_s2;
	state_t           state_s2;
	logic             online_s2;
	strobe_t          strobe_s2;

	// next-state logic
	state_t           state_d;
	strobe_t          strobe_d;
	logic             start_wait;
	logic [TimeW-1:0] wait_len_d;
	logic [TimeW-1:0] elapsed;
	logic             expired;
	logic             advance;
	logic             cfg_wr;
	reg_idx_t         cfg_idx;

	// APB: always ready, write on the access phase
	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[ApbAddrW-1:2]);
	assign cfg_wr  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wired_present_q <= 1'b0;
			wired_tmo_q     <= WiredTmoRst;
			wireless_tmo_q  <= WirelessTmoRst;
			cloud_tmo_q     <= CloudTmoRst;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_WIRED_PRESENT: wired_present_q <= pwdata[0];
				REG_WIRED_TMO:     wired_tmo_q     <= pwdata;
				REG_WIRELESS_TMO:  wireless_tmo_q  <= pwdata;
				REG_CLOUD_TMO:     cloud_tmo_q     <= pwdata;
				default: ;
			endcase
		end
	end

	// register read-back
	always_comb begin
		unique case (cfg_idx)
			REG_WIRED_PRESENT: prdata = {{(ApbDataW-1){1'b0}}, wired_present_q};
			REG_WIRED_TMO:     prdata = wired_tmo_q;
			REG_WIRELESS_TMO:  prdata = wireless_tmo_q;
			REG_CLOUD_TMO:     prdata = cloud_tmo_q;
			default:           prdata = '0;
		endcase
	end

	// handshake: the poll register moves on when the result register is free or emptying
	assign advance   = valid_s1 & (~valid_s2 | out_ready);
	assign in_ready  = ~valid_s1 | advance;

	// wait timer check, modulo 2^32
	assign elapsed = now_s1 - wait_start_q;
	assign expired = (elapsed >= wait_len_q);

	// state transition for the poll in the poll register
	always_comb begin
		state_d    = state_q;
		strobe_d   = '0;
		start_wait = 1'b0;
		wait_len_d = cloud_tmo_q;
		if (cloud_s1) begin
			state_d = state_q[StateW-1] ? ST_WL_ONLINE : ST_WIRED_ONLINE;
		end else begin
			unique case (state_q)
				ST_WIRED_ONLINE, ST_WL_ONLINE: begin
					state_d = ST_WIRED_START;
				end
				ST_WIRED_START: begin
					if (!wired_present_q) begin
						state_d = ST_WL_START;
					end else begin
						strobe_d.wireless_disconnect = 1'b1;
						strobe_d.wired_connect       = 1'b1;
						start_wait                   = 1'b1;
						wait_len_d                   = wired_tmo_q;
						state_d                      = ST_WIRED_WAIT;
					end
				end
				ST_WIRED_WAIT: begin
					if (wired_rdy_s1) begin
						strobe_d.cloud_connect = 1'b1;
						start_wait             = 1'b1;
						state_d                = ST_WIRED_CLOUD;
					end else if (expired) begin
						state_d = ST_WL_START;
					end
				end
				ST_WIRED_CLOUD: begin
					if (expired) begin
						strobe_d.cloud_disconnect = 1'b1;
						strobe_d.wired_disconnect = 1'b1;
						state_d                   = ST_WL_START;
					end
				end
				ST_WL_START: begin
					if (!creds_s1) begin
						state_d = ST_WIRED_START;
					end else begin
						strobe_d.wired_disconnect = 1'b1;
						strobe_d.wireless_connect = 1'b1;
						start_wait                = 1'b1;
						wait_len_d                = wireless_tmo_q;
						state_d                   = ST_WL_WAIT;
					end
				end
				ST_WL_WAIT: begin
					if (wl_rdy_s1) begin
						strobe_d.cloud_connect = 1'b1;
						start_wait             = 1'b1;
						state_d                = ST_WL_CLOUD;
					end else if (expired) begin
						state_d = ST_WIRED_START;
					end
				end
				ST_WL_CLOUD: begin
					if (expired) begin
						strobe_d.cloud_disconnect    = 1'b1;
						strobe_d.wireless_disconnect = 1'b1;
						state_d                      = ST_WIRED_START;
					end
				end
				default: state_d = ST_WIRED_START;
			endcase
		end
	end

	// poll register: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// poll register: payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			now_s1       <= now_ms;
			cloud_s1     <= cloud_up;
			wired_rdy_s1 <= wired_ready;
			wl_rdy_s1    <= wireless_ready;
			creds_s1     <= wireless_credentials;
		end
	end

	// controller state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_WIRED_START;
			valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_d;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// wait timer and result payload
	always_ff @(posedge clk) begin
		if (advance && start_wait) begin
			wait_start_q <= now_s1;
			wait_len_q   <= wait_len_d;
		end
		if (advance) begin
			state_s2  <= state_d;
			online_s2 <= cloud_s1;
			strobe_s2 <= strobe_d;
		end
	end

	// result ports
	assign out_valid           = valid_s2;
	assign link_state          = state_s2;
	assign online              = online_s2;
	assign wired_connect       = strobe_s2.wired_connect;
	assign wired_disconnect    = strobe_s2.wired_disconnect;
	assign wireless_connect    = strobe_s2.wireless_connect;
	assign wireless_disconnect = strobe_s2.wireless_disconnect;
	assign cloud_connect       = strobe_s2.cloud_connect;
	assign cloud_disconnect    = strobe_s2.cloud_disconnect;

	// no command strobes while the cloud is reported up
	a_no_strobe_online: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && online_s2) |-> (strobe_s2 == '0))
		else $error("strobe given while cloud up");

	// a cloud connect request always lands in a cloud wait state
	a_cloud_connect_state: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && strobe_s2.cloud_connect) |->
		(state_s2 == ST_WIRED_CLOUD || state_s2 == ST_WL_CLOUD))
		else $error("cloud connect outside cloud wait");

	// at most one link is started per poll
	a_one_link_connect: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(strobe_s2.wired_connect && strobe_s2.wireless_connect))
		else $error("both links started");

	// the reported state matches the controller state after each update
	a_state_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (state_s2 == state_q))
		else $error("reported state differs from controller state");

	// a held result stays in place
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_ready) |=> (valid_s2 && $stable(state_s2) && $stable(strobe_s2)))
		else $error("stalled result changed");

endmodule
